// File: rtl/core/lgs_pkg.sv
// Shared types and constants for the life grid generation step block.
// Field widths, item and register codes, rule constants and the window control struct.
// No dependencies.
`default_nettype none

package lgs_pkg;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W    = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int NBR_W     = 4;

  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [NBR_W-1:0] SURVIVE_MIN = 4'd2;
  localparam logic [NBR_W-1:0] SURVIVE_MAX = 4'd3;
  localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;

  typedef struct packed {
    logic shift;
    logic first;
  } win_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/lgs_in_if.sv
// Input channel of the life grid block: valid/ready handshake and the command item.
// Depends on lgs_pkg for the field widths.
`default_nettype none

interface lgs_in_if;
  logic                        valid;
  logic                        ready;
  logic [lgs_pkg::KIND_W-1:0]  kind;
  logic [lgs_pkg::ROW_W-1:0]   row;
  logic [lgs_pkg::COL_W-1:0]   col;
  logic                        value;

  modport source (output valid, kind, row, col, value, input ready);
  modport sink   (input valid, kind, row, col, value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lgs_out_if.sv
// Output channel of the life grid block: valid/ready handshake and the result item.
// No dependencies.
`default_nettype none

interface lgs_out_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic out_of_range;

  modport source (output valid, cell_alive, out_of_range, input ready);
  modport sink   (input valid, cell_alive, out_of_range, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lgs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/lgs_cell.sv
// One column cell: holds the old bits of the rows above and at the current row,
// and applies the B3/S23 rule from its own and its two neighbors' column bits.
// Depends on lgs_pkg.
`default_nettype none

module lgs_cell (
  input  wire logic                clk_i,
  input  wire lgs_pkg::win_ctrl_t  ctrl_i,
  input  wire logic                col_en_i,
  input  wire logic                dn_i,
  input  wire logic [2:0]          left_i,
  input  wire logic [2:0]          right_i,
  output logic      [2:0]          col_o,
  output logic                     next_o
);

  logic                      up_q;
  logic                      cur_q;
  logic                      up_m;
  logic                      cur_m;
  logic                      dn_m;
  logic [lgs_pkg::NBR_W-1:0] count;
  logic                      alive_next;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      up_q  <= ctrl_i.first ? 1'b0 : cur_q;
      cur_q <= dn_i;
    end
  end

  assign up_m  = up_q & col_en_i;
  assign cur_m = cur_q & col_en_i;
  assign dn_m  = dn_i & col_en_i;
  assign col_o = {up_m, cur_m, dn_m};

  assign count = lgs_pkg::NBR_W'($countones({left_i, right_i, up_m, dn_m}));

  always_comb begin
    if (cur_q) begin
      alive_next = (count == lgs_pkg::SURVIVE_MIN) || (count == lgs_pkg::SURVIVE_MAX);
    end else begin
      alive_next = (count == lgs_pkg::BIRTH_COUNT);
    end
  end

  // Columns outside the grid in use keep their stored value.
  assign next_o = col_en_i ? alive_next : cur_q;

endmodule

`default_nettype wire

// File: rtl/core/lgs_cell_row.sv
// Row of column cells chained to their left and right neighbors.
// Depends on lgs_pkg and lgs_cell.
`default_nettype none

module lgs_cell_row #(
  parameter int NUM_COLS = 64
) (
  input  wire logic                clk_i,
  input  wire lgs_pkg::win_ctrl_t  ctrl_i,
  input  wire logic [NUM_COLS-1:0] col_en_i,
  input  wire logic [NUM_COLS-1:0] dn_row_i,
  output logic      [NUM_COLS-1:0] next_row_o
);

  logic [2:0] col_bits [NUM_COLS];

  for (genvar c = 0; c < NUM_COLS; c++) begin : g_cell
    logic [2:0] left;
    logic [2:0] right;

    if (c == 0) begin : g_left_edge
      assign left = '0;
    end else begin : g_left
      assign left = col_bits[c-1];
    end

    if (c == NUM_COLS - 1) begin : g_right_edge
      assign right = '0;
    end else begin : g_right
      assign right = col_bits[c+1];
    end

    lgs_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_i),
      .col_en_i (col_en_i[c]),
      .dn_i     (dn_row_i[c]),
      .left_i   (left),
      .right_i  (right),
      .col_o    (col_bits[c]),
      .next_o   (next_row_o[c])
    );
  end

endmodule

`default_nettype wire

// File: rtl/core/life_grid_generation_step.sv
// Top level of the bounded B3/S23 life grid: command decode, row sweep control,
// grid RAM and the row of column cells. Depends on lgs_pkg, lgs_in_if, lgs_out_if,
// lgs_ram and lgs_cell_row.
//
//   Port      Dir  Handshake            Payload
//   item_i    in   valid/ready          kind, row, col, value
//   result_o  out  valid/ready          cell_alive, out_of_range
//   cfg_*     in   cfg_we_i, no wait    cfg_idx_i, cfg_wdata_i
//
// A read or write inside the grid passes through ST_ACCESS and then ST_RESULT to a valid result;
// an item that touches no grid row, such as an access outside the grid, goes straight to ST_RESULT.
// An advance runs ST_ADV_LOAD, then ST_ADV_RUN one grid row per cycle through the cell row, then ST_RESULT.
// After reset the grid RAM is cleared one row per cycle over all MAX_ROWS rows; no item is
// taken meanwhile. One item is in work at a time; a result waiting in the output
// register does not block acceptance, but a finished item waits for it to drain.
`default_nettype none

module life_grid_generation_step #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  lgs_in_if.sink                                 item_i,
  lgs_out_if.source                              result_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [lgs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [lgs_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int REW = (RCW > lgs_pkg::CFG_W) ? RCW : lgs_pkg::CFG_W;
  localparam int CEW = (CCW > lgs_pkg::CFG_W) ? CCW : lgs_pkg::CFG_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_ADV_LOAD,
    ST_ADV_RUN,
    ST_RESULT
  } state_e;

  state_e                       state_q;
  logic [REW-1:0]               cnt_q;
  logic [lgs_pkg::KIND_W-1:0]   kind_q;
  logic [AW-1:0]                row_q;
  logic [CW-1:0]                col_q;
  logic                         value_q;
  logic                         res_alive_q;
  logic                         res_oor_q;
  logic                         out_vld_q;
  logic                         out_alive_q;
  logic                         out_oor_q;
  logic [lgs_pkg::CFG_W-1:0]    rows_q;
  logic [lgs_pkg::CFG_W-1:0]    cols_q;

  logic [REW-1:0]               rows_eff;
  logic [CEW-1:0]               cols_eff;
  logic                         addr_inside;
  logic                         below_ok;
  logic                         ahead_ok;
  logic                         out_free;
  logic [MAX_COLS-1:0]          col_en;
  logic [MAX_COLS-1:0]          below_row;
  logic [MAX_COLS-1:0]          next_row;
  logic [MAX_COLS-1:0]          patched_row;
  lgs_pkg::win_ctrl_t           win_ctrl;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [MAX_COLS-1:0]          ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [MAX_COLS-1:0]          ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lgs_pkg::CFG_RESET;
      cols_q <= lgs_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lgs_pkg::CFG_ROWS: rows_q <= cfg_wdata_i;
        lgs_pkg::CFG_COLS: cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rows_eff = (REW'(rows_q) > REW'(MAX_ROWS)) ? REW'(MAX_ROWS) : REW'(rows_q);
  assign cols_eff = (CEW'(cols_q) > CEW'(MAX_COLS)) ? CEW'(MAX_COLS) : CEW'(cols_q);

  assign addr_inside = (REW'(item_i.row) < rows_eff) && (CEW'(item_i.col) < cols_eff);
  assign below_ok    = (cnt_q + REW'(1)) < rows_eff;
  assign ahead_ok    = ({1'b0, cnt_q} + (REW + 1)'(2)) < {1'b0, rows_eff};
  assign out_free    = !out_vld_q || result_o.ready;

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col_en
    assign col_en[c] = CEW'(c) < cols_eff;
  end

  // The row below the last row in use counts as dead.
  assign below_row = ((state_q == ST_ADV_RUN) && !below_ok) ? '0 : ram_rdata;

  always_comb begin
    patched_row        = ram_rdata;
    patched_row[col_q] = value_q;
  end

  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = AW'(cnt_q);
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = AW'(item_i.row);
    win_ctrl.shift = 1'b0;
    win_ctrl.first = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (item_i.valid) begin
          case (item_i.kind) inside
            lgs_pkg::KIND_WRITE, lgs_pkg::KIND_READ: begin
              ram_re = addr_inside;
            end
            lgs_pkg::KIND_ADVANCE: begin
              ram_re    = (rows_eff != '0);
              ram_raddr = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ACCESS: begin
        ram_we    = (kind_q == lgs_pkg::KIND_WRITE);
        ram_waddr = row_q;
        ram_wdata = patched_row;
      end
      ST_ADV_LOAD: begin
        win_ctrl.shift = 1'b1;
        win_ctrl.first = 1'b1;
        ram_re         = (rows_eff > REW'(1));
        ram_raddr      = AW'(1);
      end
      ST_ADV_RUN: begin
        win_ctrl.shift = 1'b1;
        ram_we         = 1'b1;
        ram_wdata      = next_row;
        ram_re         = ahead_ok;
        ram_raddr      = AW'(cnt_q + REW'(2));
      end
      ST_RESULT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      kind_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      value_q     <= 1'b0;
      res_alive_q <= 1'b0;
      res_oor_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      out_alive_q <= 1'b0;
      out_oor_q   <= 1'b0;
    end else begin
      if (result_o.ready && !((state_q == ST_RESULT) && out_free)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (cnt_q == REW'(MAX_ROWS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + REW'(1);
          end
        end
        ST_IDLE: begin
          if (item_i.valid) begin
            kind_q      <= item_i.kind;
            row_q       <= AW'(item_i.row);
            col_q       <= CW'(item_i.col);
            value_q     <= item_i.value;
            res_alive_q <= 1'b0;
            case (item_i.kind) inside
              lgs_pkg::KIND_WRITE, lgs_pkg::KIND_READ: begin
                if (addr_inside) begin
                  res_oor_q <= 1'b0;
                  state_q   <= ST_ACCESS;
                end else begin
                  res_oor_q <= 1'b1;
                  state_q   <= ST_RESULT;
                end
              end
              lgs_pkg::KIND_ADVANCE: begin
                res_oor_q <= 1'b0;
                state_q   <= (rows_eff != '0) ? ST_ADV_LOAD : ST_RESULT;
              end
              default: begin
                res_oor_q <= 1'b0;
                state_q   <= ST_RESULT;
              end
            endcase
          end
        end
        ST_ACCESS: begin
          res_alive_q <= (kind_q == lgs_pkg::KIND_READ) && ram_rdata[col_q];
          state_q     <= ST_RESULT;
        end
        ST_ADV_LOAD: begin
          cnt_q   <= '0;
          state_q <= ST_ADV_RUN;
        end
        ST_ADV_RUN: begin
          cnt_q <= cnt_q + REW'(1);
          if (!below_ok) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_alive_q <= res_alive_q;
            out_oor_q   <= res_oor_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign item_i.ready          = (state_q == ST_IDLE);
  assign result_o.valid        = out_vld_q;
  assign result_o.cell_alive   = out_alive_q;
  assign result_o.out_of_range = out_oor_q;

  lgs_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lgs_cell_row #(
    .NUM_COLS (MAX_COLS)
  ) u_cell_row (
    .clk_i      (clk_i),
    .ctrl_i     (win_ctrl),
    .col_en_i   (col_en),
    .dn_row_i   (below_row),
    .next_row_o (next_row)
  );

endmodule

`default_nettype wire
